// ----- sv/sha_pkg.sv -----
`timescale 1ns / 1ps

package sha_pkg;

   localparam int WORD_W  = 32;
   localparam int COUNT_W = 61;
   localparam int ROUNDS  = 64;
   localparam int WORDS   = 16;
   localparam int DIGESTS = 8;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [WORD_W-1:0] H_INIT [DIGESTS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_LEN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       byte_wr;
      logic       pad;
      logic       len;
      logic       zero_low;
      logic       load_work;
      logic       round;
      logic       fold;
      logic       restart;
      logic [5:0] round_idx;
      logic [2:0] out_idx;
   } cmd_type;

   typedef struct packed {
      logic [5:0] fill;
   } status_type;

   function automatic logic [WORD_W-1:0] round_k(input logic [5:0] t);
      logic [WORD_W-1:0] k;
      case (t)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = '0;
      endcase
      return k;
   endfunction

endpackage

// ----- sv/sha_ctrl.sv -----
`timescale 1ns / 1ps

module sha_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_has_byte,
   input  logic                req_last_byte,
   output logic                req_stall,
   output logic                rsp_valid,
   output logic                rsp_final_word,
   input  logic                rsp_stall,
   input  sha_pkg::status_type status,
   output sha_pkg::cmd_type    cmd
);

   sha_pkg::state_type state_ff, state_in;
   sha_pkg::state_type post_ff, post_in;
   logic [5:0] round_ff, round_in;
   logic [2:0] idx_ff, idx_in;
   logic       wrap_ff, wrap_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha_pkg::ST_IDLE;
         post_ff  <= sha_pkg::ST_IDLE;
         round_ff <= '0;
         idx_ff   <= '0;
         wrap_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         post_ff  <= post_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
         wrap_ff  <= wrap_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      post_in  = post_ff;
      round_in = round_ff;
      idx_in   = idx_ff;
      wrap_in  = wrap_ff;
      cmd      = '0;
      cmd.round_idx = round_ff;
      cmd.out_idx   = idx_ff;
      req_stall      = (state_ff != sha_pkg::ST_IDLE);
      rsp_valid      = (state_ff == sha_pkg::ST_OUT);
      rsp_final_word = rsp_valid && (idx_ff == 3'd7);

      case (state_ff)
         sha_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_has_byte) begin
                  cmd.byte_wr = 1'b1;
                  if (status.fill == 6'd63) begin
                     cmd.load_work = 1'b1;
                     round_in      = '0;
                     state_in      = sha_pkg::ST_ROUND;
                     post_in       = req_last_byte ? sha_pkg::ST_PAD : sha_pkg::ST_IDLE;
                  end else if (req_last_byte) begin
                     state_in = sha_pkg::ST_PAD;
                  end
               end else if (req_last_byte) begin
                  state_in = sha_pkg::ST_PAD;
               end
            end
         end
         sha_pkg::ST_PAD: begin
            cmd.pad = 1'b1;
            if (status.fill[5:3] == 3'b111) begin
               // pad does not leave room for the length: run one extra block
               cmd.load_work = 1'b1;
               round_in      = '0;
               wrap_in       = 1'b1;
               post_in       = sha_pkg::ST_LEN;
               state_in      = sha_pkg::ST_ROUND;
            end else begin
               state_in = sha_pkg::ST_LEN;
            end
         end
         sha_pkg::ST_LEN: begin
            cmd.len       = 1'b1;
            cmd.zero_low  = wrap_ff;
            cmd.load_work = 1'b1;
            wrap_in       = 1'b0;
            round_in      = '0;
            post_in       = sha_pkg::ST_OUT;
            state_in      = sha_pkg::ST_ROUND;
         end
         sha_pkg::ST_ROUND: begin
            cmd.round = 1'b1;
            round_in  = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = sha_pkg::ST_FOLD;
            end
         end
         sha_pkg::ST_FOLD: begin
            cmd.fold = 1'b1;
            idx_in   = '0;
            state_in = post_ff;
         end
         sha_pkg::ST_OUT: begin
            if (!rsp_stall) begin
               if (idx_ff == 3'd7) begin
                  cmd.restart = 1'b1;
                  idx_in      = '0;
                  state_in    = sha_pkg::ST_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = sha_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- sv/sha_dp.sv -----
`timescale 1ns / 1ps

module sha_dp (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          data_byte,
   input  sha_pkg::cmd_type    cmd,
   output sha_pkg::status_type status,
   output logic [31:0]         digest_word
);

   logic [31:0] hash_ff [sha_pkg::DIGESTS];
   logic [31:0] hash_in [sha_pkg::DIGESTS];
   logic [31:0] work_ff [sha_pkg::DIGESTS];
   logic [31:0] work_in [sha_pkg::DIGESTS];
   logic [31:0] w_ff    [sha_pkg::WORDS];
   logic [31:0] w_in    [sha_pkg::WORDS];
   logic [sha_pkg::COUNT_W-1:0] count_ff, count_in;

   logic [31:0] big0, big1, choose, major, sum1, sum2, sig0, sig1, w_next;
   logic [5:0]  pos;

   function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff  <= sha_pkg::H_INIT;
         count_ff <= '0;
      end else begin
         hash_ff  <= hash_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      w_ff    <= w_in;
   end

   assign status.fill = count_ff[5:0];
   assign digest_word = hash_ff[cmd.out_idx];

   always_comb begin
      big1   = rotr(work_ff[4], 6) ^ rotr(work_ff[4], 11) ^ rotr(work_ff[4], 25);
      choose = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      big0   = rotr(work_ff[0], 2) ^ rotr(work_ff[0], 13) ^ rotr(work_ff[0], 22);
      major  = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
             ^ (work_ff[1] & work_ff[2]);
      sum1   = work_ff[7] + big1 + choose + sha_pkg::round_k(cmd.round_idx) + w_ff[0];
      sum2   = big0 + major;
      sig0   = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      sig1   = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_next = sig1 + w_ff[9] + sig0 + w_ff[0];
   end

   always_comb begin
      hash_in  = hash_ff;
      work_in  = work_ff;
      w_in     = w_ff;
      count_in = count_ff;
      pos      = '0;

      if (cmd.byte_wr) begin
         count_in = count_ff + 61'd1;
         w_in[count_ff[5:2]][8*(3 - 32'(count_ff[1:0])) +: 8] = data_byte;
      end

      if (cmd.pad) begin
         for (int i = 0; i < sha_pkg::WORDS; i++) begin
            for (int k = 0; k < 4; k++) begin
               pos = 6'(4 * i + k);
               if (pos == count_ff[5:0]) begin
                  w_in[i][8*(3 - k) +: 8] = sha_pkg::PAD_BYTE;
               end else if (pos > count_ff[5:0]) begin
                  w_in[i][8*(3 - k) +: 8] = 8'h00;
               end
            end
         end
      end

      if (cmd.len) begin
         if (cmd.zero_low) begin
            for (int i = 0; i < sha_pkg::WORDS - 2; i++) begin
               w_in[i] = '0;
            end
         end
         w_in[14] = count_ff[60:29];
         w_in[15] = {count_ff[28:0], 3'b000};
      end

      if (cmd.load_work) begin
         work_in = hash_ff;
      end

      if (cmd.round) begin
         for (int i = 0; i < sha_pkg::WORDS - 1; i++) begin
            w_in[i] = w_ff[i + 1];
         end
         w_in[15]   = w_next;
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + sum1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = sum1 + sum2;
      end

      if (cmd.fold) begin
         for (int i = 0; i < sha_pkg::DIGESTS; i++) begin
            hash_in[i] = hash_ff[i] + work_ff[i];
         end
      end

      if (cmd.restart) begin
         hash_in  = sha_pkg::H_INIT;
         count_in = '0;
      end
   end

endmodule

// ----- sv/sha256_stream_hasher.sv -----
`timescale 1ns / 1ps
// SHA-256 over a byte stream.
// Request channel: req_data_byte, req_has_byte, req_last_byte with req_valid and
// req_stall. A byte is taken when req_valid is high and req_stall is low; MSB
// byte first within each message word. req_has_byte low with req_last_byte high
// closes the message without a byte.
// Response channel: eight transfers of rsp_digest_word with rsp_word_index 0..7,
// rsp_final_word high on the eighth.
// Throughput: one byte per cycle while a block fills; the 64th byte of a block
// starts the round loop and then the fold, during which req_stall is high.
// From the last byte to the first digest word the steps are pad, length,
// rounds and fold; when the pad leaves no room for the length, an extra block
// of rounds and fold comes between pad and length, and when the last byte
// itself completes a block, its rounds and fold come before the pad.
// While the receiver stalls, the digest word holds and no new bytes are taken.
// After the eighth transfer the chaining words return to the initial values
// and the byte count to zero. Reset (synchronous) does the same and drops any
// message in progress.

module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_final_word
);

   sha_pkg::cmd_type    cmd;
   sha_pkg::status_type status;

   sha_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_has_byte   (req_has_byte),
      .req_last_byte  (req_last_byte),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_final_word (rsp_final_word),
      .rsp_stall      (rsp_stall),
      .status         (status),
      .cmd            (cmd)
   );

   sha_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .data_byte   (req_data_byte),
      .cmd         (cmd),
      .status      (status),
      .digest_word (rsp_digest_word)
   );

   assign rsp_word_index = cmd.out_idx;

`ifndef SYNTH
   a_out_blocks_in: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while digest is out");

   a_last_ends_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_final_word |=> !rsp_valid && !req_stall)
      else $error("digest did not end after final word");

   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_final_word |=>
         rsp_valid && (rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest word index skipped");

   a_round_stalls: assert property (@(posedge clock) disable iff (reset)
      cmd.round |-> req_stall && !rsp_valid)
      else $error("round loop overlapped a transfer");
`endif

endmodule
